>>> rtl/itf_pkg.sv
// shared types and constants for the integer to text formatter
// no dependencies
package itf_pkg;

    localparam int MAX_DIGITS = 64;
    localparam int MAX_ROOM   = 64;
    localparam int DIG_AW     = $clog2(MAX_DIGITS);
    localparam int BIT_CW     = 6;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_RADIX = 2'd1;
    localparam logic [1:0] ST_NO_ROOM   = 2'd2;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_LB    = 8'h62;
    localparam logic [7:0] CH_LX    = 8'h78;
    // letter base minus ten
    localparam logic [7:0] CH_UPPER_OFS = 8'd55;
    localparam logic [7:0] CH_LOWER_OFS = 8'd87;

    typedef enum logic [1:0] {PH_IDLE, PH_DIVIDE, PH_EMIT} t_phase;
    typedef enum logic {DV_IDLE, DV_RUN} t_div_state;
    typedef enum logic [2:0] {EM_IDLE, EM_PREP, EM_READ, EM_SEND, EM_ERR} t_emit_state;

    typedef struct packed {
        logic              we;
        logic [DIG_AW-1:0] addr;
        logic [5:0]        data;
    } t_dig_wr;

    typedef struct packed {
        logic [1:0]      hlen;
        logic [2:0][7:0] head;
        logic [6:0]      width;
        logic [6:0]      prec;
        logic [6:0]      room;
        logic            f_prec;
        logic            f_zero;
        logic            f_left;
        logic            f_upper;
        logic [1:0]      status;
    } t_layout;

endpackage

>>> rtl/itf_div.sv
// bit-serial restoring divider that peels off one digit per pass
// depends on itf_pkg
module itf_div import itf_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_dividend,
    input  logic [5:0]  i_radix,
    output t_dig_wr     o_wr,
    output logic        o_done,
    output logic [6:0]  o_count
);

    t_div_state        r_state, n_state;
    logic [63:0]       r_q, n_q;
    logic [5:0]        r_rem, n_rem;
    logic [5:0]        r_radix;
    logic [BIT_CW-1:0] r_bit, n_bit;
    logic [6:0]        r_cnt, n_cnt;

    logic [6:0]  rem2;
    logic        ge;
    logic [5:0]  rnew;
    logic [63:0] qnext;
    logic        last_bit;

    always_comb begin
        rem2     = {r_rem, r_q[63]};
        ge       = rem2 >= {1'b0, r_radix};
        rnew     = ge ? 6'(rem2 - {1'b0, r_radix}) : rem2[5:0];
        qnext    = {r_q[62:0], ge};
        last_bit = r_bit == BIT_CW'(63);
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            DV_IDLE: if (i_start) n_state = DV_RUN;
            DV_RUN:  if (last_bit && qnext == 64'd0) n_state = DV_IDLE;
            default: n_state = DV_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb begin
        n_q     = r_q;
        n_rem   = r_rem;
        n_bit   = r_bit;
        n_cnt   = r_cnt;
        o_wr    = '0;
        o_done  = 1'b0;
        case (r_state)
            DV_IDLE: begin
                if (i_start) begin
                    n_q   = i_dividend;
                    n_rem = '0;
                    n_bit = '0;
                    n_cnt = '0;
                end
            end
            DV_RUN: begin
                n_q   = qnext;
                n_rem = rnew;
                n_bit = BIT_CW'(r_bit + 1'b1);
                if (last_bit) begin
                    n_rem     = '0;
                    o_wr.we   = r_cnt < 7'(MAX_DIGITS);
                    o_wr.addr = r_cnt[DIG_AW-1:0];
                    o_wr.data = rnew;
                    if (r_cnt < 7'(MAX_DIGITS)) n_cnt = 7'(r_cnt + 1'b1);
                    o_done = qnext == 64'd0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= DV_IDLE;
            r_cnt   <= '0;
            r_bit   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_bit   <= n_bit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q   <= n_q;
        r_rem <= n_rem;
        if (r_state == DV_IDLE && i_start) r_radix <= i_radix;
    end

    assign o_count = n_cnt;

endmodule

>>> rtl/itf_emit.sv
// digit store, field layout and character sequencer with output register
// depends on itf_pkg
module itf_emit import itf_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_dig_wr    i_wr,
    input  logic       i_start,
    input  logic       i_start_err,
    input  logic [6:0] i_count,
    input  t_layout    i_lay,
    input  logic       i_out_stall,
    output logic       o_done,
    output logic       o_out_valid,
    output logic [7:0] o_out_char,
    output logic       o_char_valid,
    output logic       o_last,
    output logic [1:0] o_status,
    output logic [6:0] o_total_length
);

    t_emit_state r_state, n_state;
    logic [5:0]  r_mem [MAX_DIGITS];
    logic [5:0]  r_rd;
    logic [6:0]  r_dc;
    logic [6:0]  r_b1, r_b2, r_b3, r_b4, r_end, r_pos, n_pos;
    logic        r_ov, n_ov;
    logic [7:0]  r_ch, n_ch;
    logic        r_cv, n_cv, r_last, n_last;
    logic [1:0]  r_st, n_st;
    logic [6:0]  r_tl, n_tl;

    logic        free;
    logic [6:0]  len, w1, p1, w2, wp, pl, lead, nz, lim, lead_hd, lead_hz;
    logic [6:0]  pos1;
    logic        is_last;
    logic [7:0]  dig_ch, ch;
    logic [1:0]  hofs;
    logic [DIG_AW-1:0] raddr;

    assign free = !r_ov || !i_out_stall;

    // layout from digit count and head length
    always_comb begin
        len  = 7'(r_dc + 7'(i_lay.hlen));
        w1   = i_lay.width > len ? i_lay.width : len;
        p1   = i_lay.f_prec ? (i_lay.prec > len ? i_lay.prec : len) : w1;
        w2   = w1 > p1 ? w1 : p1;
        wp   = 7'(w2 - p1);
        pl   = 7'(p1 - len);
        lead = 7'((i_lay.f_left ? 7'd0 : wp)
             + ((!i_lay.f_zero && (i_lay.f_prec || !i_lay.f_left)) ? pl : 7'd0));
        nz   = i_lay.f_zero ? pl : 7'd0;
        lim  = i_lay.room > 7'(MAX_ROOM) ? 7'(MAX_ROOM) : i_lay.room;
        lead_hd = 7'(lead + 7'(i_lay.hlen));
        lead_hz = 7'(lead_hd + nz);
    end

    always_comb begin
        pos1    = 7'(r_pos + 1'b1);
        is_last = pos1 == r_end;
        raddr   = DIG_AW'(7'(r_b4 - 7'd1 - r_pos));
        dig_ch  = 8'(r_rd) + (r_rd < 6'd10 ? CH_ZERO
                             : (i_lay.f_upper ? CH_UPPER_OFS : CH_LOWER_OFS));
        hofs    = 2'(r_pos - r_b1);
        if (r_pos < r_b1)      ch = CH_SPACE;
        else if (r_pos < r_b2) ch = i_lay.head[hofs];
        else if (r_pos < r_b3) ch = CH_ZERO;
        else if (r_pos < r_b4) ch = dig_ch;
        else                   ch = CH_SPACE;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            EM_IDLE: begin
                if (i_start_err)  n_state = EM_ERR;
                else if (i_start) n_state = EM_PREP;
            end
            EM_PREP: n_state = EM_READ;
            EM_READ: n_state = EM_SEND;
            EM_SEND: if (free) n_state = is_last ? EM_IDLE : EM_READ;
            EM_ERR:  if (free) n_state = EM_IDLE;
            default: n_state = EM_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        n_pos  = r_pos;
        n_ov   = r_ov && i_out_stall;
        n_ch   = r_ch;
        n_cv   = r_cv;
        n_last = r_last;
        n_st   = r_st;
        n_tl   = r_tl;
        o_done = 1'b0;
        case (r_state)
            EM_PREP: n_pos = '0;
            EM_SEND: begin
                if (free) begin
                    n_ov   = 1'b1;
                    n_ch   = ch;
                    n_cv   = 1'b1;
                    n_last = is_last;
                    n_st   = ST_OK;
                    n_tl   = is_last ? pos1 : 7'd0;
                    n_pos  = pos1;
                    o_done = is_last;
                end
            end
            EM_ERR: begin
                if (free) begin
                    n_ov   = 1'b1;
                    n_ch   = '0;
                    n_cv   = 1'b0;
                    n_last = 1'b1;
                    n_st   = i_lay.status;
                    n_tl   = '0;
                    o_done = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= EM_IDLE;
            r_ov    <= 1'b0;
            r_pos   <= '0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
            r_pos   <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.we) r_mem[i_wr.addr] <= i_wr.data;
        r_rd <= r_mem[raddr];
    end

    always_ff @(posedge i_clk) begin
        r_ch   <= n_ch;
        r_cv   <= n_cv;
        r_last <= n_last;
        r_st   <= n_st;
        r_tl   <= n_tl;
        if (r_state == EM_IDLE && i_start) r_dc <= i_count;
        if (r_state == EM_PREP) begin
            r_b1  <= lead;
            r_b2  <= lead_hd;
            r_b3  <= lead_hz;
            r_b4  <= 7'(lead_hz + r_dc);
            r_end <= w2 < lim ? w2 : lim;
        end
    end

    assign o_out_valid    = r_ov;
    assign o_out_char     = r_ch;
    assign o_char_valid   = r_cv;
    assign o_last         = r_last;
    assign o_status       = r_st;
    assign o_total_length = r_tl;

endmodule

>>> rtl/integer_to_text_formatter.sv
// top level of the integer to text formatter: input capture and phase control
// depends on itf_pkg, itf_div and itf_emit
//
// Usage:
// - input channel: i_in_valid with o_in_stall; a word is taken at a clock edge
//   with valid high and stall low. o_in_stall stays high from then until the
//   last character of the run is loaded into the output register.
// - output channel: o_out_valid with i_out_stall; one character per word, the
//   final word of a run carries o_last and o_total_length.
// - sequence: a bad radix or zero room gives one error word, loaded from the
//   error state into the output register. Otherwise the bit-serial divider
//   works through all 64 dividend bits for each digit (one quotient bit per
//   cycle), then a layout step, then per character a digit store read and an output load.
// - one value is in work at a time; the divider loop takes most of each run.
// - the output register decouples the sides; a stalled receiver holds the word
//   and the sequencer waits, and the next value may be accepted while the last
//   word of the previous run is still held.
// - reset (synchronous, active low) returns all control to idle and empties
//   the output register; the digit store is not cleared.
module integer_to_text_formatter import itf_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [63:0] i_value,
    input  logic [5:0]  i_radix,
    input  logic [6:0]  i_width,
    input  logic [6:0]  i_precision,
    input  logic [6:0]  i_room,
    input  logic [6:0]  i_format_flags,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_out_char,
    output logic        o_char_valid,
    output logic        o_last,
    output logic [1:0]  o_status,
    output logic [6:0]  o_total_length
);

    t_phase  r_phase, n_phase;
    t_layout r_lay, n_lay;

    logic        accept, err, neg, has_sign;
    logic [1:0]  plen;
    logic [7:0]  sgn_ch, pre0, pre1;
    logic [63:0] mag;
    logic        div_start, emit_start, emit_err;
    logic        div_done, emit_done;
    logic [6:0]  dig_count;
    t_dig_wr     dig_wr;

    assign o_in_stall = r_phase != PH_IDLE;
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        err      = i_room == 7'd0 || i_radix < 6'd2 || i_radix > 6'd36;
        neg      = !i_format_flags[0] && i_value[63];
        mag      = neg ? 64'(64'd0 - i_value) : i_value;
        has_sign = i_format_flags[2] || neg;
        sgn_ch   = neg ? CH_MINUS : CH_PLUS;
        plen     = '0;
        pre0     = CH_ZERO;
        pre1     = CH_ZERO;
        if (i_format_flags[3]) begin
            case (i_radix)
                6'd2:    begin plen = 2'd2; pre1 = CH_LB; end
                6'd8:    plen = 2'd1;
                6'd16:   begin plen = 2'd2; pre1 = CH_LX; end
                default: plen = 2'd0;
            endcase
        end
        n_lay.hlen    = 2'(plen + {1'b0, has_sign});
        n_lay.head[0] = has_sign ? sgn_ch : pre0;
        n_lay.head[1] = has_sign ? pre0 : pre1;
        n_lay.head[2] = pre1;
        n_lay.width   = i_width;
        n_lay.prec    = i_precision;
        n_lay.room    = i_room;
        n_lay.f_upper = i_format_flags[1];
        n_lay.f_prec  = i_format_flags[4];
        n_lay.f_zero  = i_format_flags[5];
        n_lay.f_left  = i_format_flags[6];
        n_lay.status  = i_room == 7'd0 ? ST_NO_ROOM : (err ? ST_BAD_RADIX : ST_OK);
    end

    // next state
    always_comb begin
        n_phase = r_phase;
        case (r_phase)
            PH_IDLE:   if (accept) n_phase = err ? PH_EMIT : PH_DIVIDE;
            PH_DIVIDE: if (div_done) n_phase = PH_EMIT;
            PH_EMIT:   if (emit_done) n_phase = PH_IDLE;
            default:   n_phase = PH_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        div_start  = 1'b0;
        emit_start = 1'b0;
        emit_err   = 1'b0;
        case (r_phase)
            PH_IDLE: begin
                div_start = accept && !err;
                emit_err  = accept && err;
            end
            PH_DIVIDE: emit_start = div_done;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_phase <= PH_IDLE;
        else          r_phase <= n_phase;
    end

    always_ff @(posedge i_clk) begin
        if (accept) r_lay <= n_lay;
    end

    itf_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (mag),
        .i_radix    (i_radix),
        .o_wr       (dig_wr),
        .o_done     (div_done),
        .o_count    (dig_count)
    );

    itf_emit u_emit (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_wr           (dig_wr),
        .i_start        (emit_start),
        .i_start_err    (emit_err),
        .i_count        (dig_count),
        .i_lay          (r_lay),
        .i_out_stall    (i_out_stall),
        .o_done         (emit_done),
        .o_out_valid    (o_out_valid),
        .o_out_char     (o_out_char),
        .o_char_valid   (o_char_valid),
        .o_last         (o_last),
        .o_status       (o_status),
        .o_total_length (o_total_length)
    );

endmodule

>>> rtl/itf_checker.sv
// port-level checks for the integer to text formatter, bound to the top level
// depends on integer_to_text_formatter
module itf_port_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_stall,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic       o_char_valid,
    input logic       o_last,
    input logic [1:0] o_status,
    input logic [6:0] o_total_length
);

    // block is busy right after taking a word
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("not busy after accept");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("stalled output dropped");

    // error words carry no character and no length
    a_err_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != 2'd0 |-> o_last && !o_char_valid
            && o_total_length == 7'd0)
        else $error("bad error word");

    a_mid_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_last |-> o_char_valid && o_status == 2'd0
            && o_total_length == 7'd0)
        else $error("bad character word");

    a_ok_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_last && o_status == 2'd0 |-> o_total_length != 7'd0)
        else $error("zero length on final word");

endmodule

bind integer_to_text_formatter itf_port_checker u_itf_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_char_valid   (o_char_valid),
    .o_last         (o_last),
    .o_status       (o_status),
    .o_total_length (o_total_length)
);
